// File: rtl/u16u8_pkg.sv
// shared types, constants and encoding functions for the utf-16 to utf-8 transcoder
`timescale 1ns / 1ps
`default_nettype none
package u16u8_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [7:0]  NULL_BYTE      = 8'h00;
  localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

  typedef enum logic [1:0] {
    REG_MODIFIED_NULL     = 2'd0,
    REG_WRITE_BUFFER_MODE = 2'd1,
    REG_OUT_CAPACITY      = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic        modified_null;
    logic        write_buffer_mode;
    logic [15:0] out_capacity;
  } cfg_t;

  // up to two code points per code unit, plus the end-of-string mark
  typedef struct packed {
    logic        va;
    logic [20:0] cpa;
    logic [2:0]  sza;
    logic        vb;
    logic [20:0] cpb;
    logic [2:0]  szb;
    logic        last;
  } job_t;

  function automatic logic is_high(input logic [15:0] u);
    return u[15:10] == 6'b110110;
  endfunction

  function automatic logic is_low(input logic [15:0] u);
    return u[15:10] == 6'b110111;
  endfunction

  function automatic logic [2:0] cp_size(input logic [20:0] cp, input cfg_t cfg);
    logic [2:0] sz;
    if (cp == 21'd0) begin
      sz = cfg.write_buffer_mode ? 3'd1 : (cfg.modified_null ? 3'd2 : 3'd0);
    end else if (cp < 21'h80) begin
      sz = 3'd1;
    end else if (cp < 21'h800) begin
      sz = 3'd2;
    end else if (cp < 21'h10000) begin
      sz = 3'd3;
    end else begin
      sz = 3'd4;
    end
    return sz;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] sz,
                                           input logic [2:0] idx);
    logic [7:0] b;
    b = NULL_BYTE;
    case (sz)
      3'd1: b = cp[7:0];
      3'd2: b = (idx == 3'd0) ? (8'hC0 | {3'b000, cp[10:6]}) : (8'h80 | {2'b00, cp[5:0]});
      3'd3: begin
        case (idx)
          3'd0:    b = 8'hE0 | {4'h0, cp[15:12]};
          3'd1:    b = 8'h80 | {2'b00, cp[11:6]};
          default: b = 8'h80 | {2'b00, cp[5:0]};
        endcase
      end
      3'd4: begin
        case (idx)
          3'd0:    b = 8'hF0 | {5'h00, cp[20:18]};
          3'd1:    b = 8'h80 | {2'b00, cp[17:12]};
          3'd2:    b = 8'h80 | {2'b00, cp[11:6]};
          default: b = 8'h80 | {2'b00, cp[5:0]};
        endcase
      end
      default: b = NULL_BYTE;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// File: rtl/utf16_to_utf8_transcoder_top.sv
// a unit's job goes through the queue and the emitter's job registers to the output register
// throughput: one output byte per cycle from the emitter while out_stall is low; a unit
// yields as many bytes as its code points need (none for a high surrogate held for its pair),
// e.g. three for a bmp character above U+07FF
// a four-entry job queue lets the input side run ahead while the emitter works
// reset: synchronous, clears surrogate hold, bytes-written count, capacity flag, queue and output valid
`timescale 1ns / 1ps
`default_nettype none
module utf16_to_utf8_transcoder_top #(
  parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] code_unit,
  input  wire logic        last_unit,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             has_byte,
  output logic             run_last,
  output logic             string_done,
  output logic [15:0]      byte_count
);

  u16u8_pkg::cfg_t cfg;
  u16u8_pkg::job_t push_job;
  u16u8_pkg::job_t head_job;
  logic            push;
  logic            pop;
  logic            full;
  logic            empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.modified_null     <= 1'b0;
      cfg.write_buffer_mode <= 1'b0;
      cfg.out_capacity      <= u16u8_pkg::CAPACITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (u16u8_pkg::reg_index_t'(cfg_index))
        u16u8_pkg::REG_MODIFIED_NULL:     cfg.modified_null     <= cfg_data[0];
        u16u8_pkg::REG_WRITE_BUFFER_MODE: cfg.write_buffer_mode <= cfg_data[0];
        u16u8_pkg::REG_OUT_CAPACITY:      cfg.out_capacity      <= cfg_data;
        default: ;
      endcase
    end
  end

  u16u8_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .code_unit (code_unit),
    .last_unit (last_unit),
    .full      (full),
    .push      (push),
    .job       (push_job)
  );

  u16u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_job),
    .pop   (pop),
    .rdata (head_job),
    .full  (full),
    .empty (empty)
  );

  u16u8_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .job         (head_job),
    .empty       (empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .has_byte    (has_byte),
    .run_last    (run_last),
    .string_done (string_done),
    .byte_count  (byte_count)
  );

  a_done_is_run_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && string_done |-> run_last)
    else $error("string end not on last byte of its unit");

  a_status_item: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_byte |-> out_byte == 8'h00 && run_last && string_done)
    else $error("status-only transaction malformed");

  a_reset_clears_output: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");

  a_count_advances: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && has_byte && !run_last ##1 out_valid |->
      has_byte && byte_count == $past(byte_count) + 16'd1)
    else $error("byte count not advancing within a unit");

endmodule
`default_nettype wire

// File: rtl/u16u8_front.sv
// front end: accepts code units, pairs surrogates and classifies code points
`timescale 1ns / 1ps
`default_nettype none
module u16u8_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire u16u8_pkg::cfg_t   cfg,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [15:0]       code_unit,
  input  wire logic              last_unit,
  input  wire logic              full,
  output logic                   push,
  output u16u8_pkg::job_t        job
);

  logic        held_valid;
  logic [15:0] held_high;
  logic        accept;
  logic        u_high;
  logic        u_low;
  logic        alone_v;
  logic [20:0] alone_cp;

  assign in_stall = full;
  assign accept   = in_valid && !full;
  assign u_high   = u16u8_pkg::is_high(code_unit);
  assign u_low    = u16u8_pkg::is_low(code_unit);

  // the unit decoded on its own
  always_comb begin
    alone_v  = 1'b1;
    alone_cp = {5'd0, code_unit};
    if (u_low) begin
      alone_cp = u16u8_pkg::REPLACEMENT_CP;
    end else if (u_high) begin
      alone_cp = u16u8_pkg::REPLACEMENT_CP;
      alone_v  = last_unit;
    end
  end

  always_comb begin
    job      = '0;
    job.last = last_unit;
    if (held_valid && u_low) begin
      job.va  = 1'b1;
      job.cpa = {1'b0, held_high[9:0], code_unit[9:0]} + 21'h10000;
    end else if (held_valid) begin
      job.va  = 1'b1;
      job.cpa = u16u8_pkg::REPLACEMENT_CP;
      job.vb  = alone_v;
      job.cpb = alone_cp;
    end else begin
      job.va  = alone_v;
      job.cpa = alone_cp;
    end
    job.sza = u16u8_pkg::cp_size(job.cpa, cfg);
    job.szb = u16u8_pkg::cp_size(job.cpb, cfg);
  end

  assign push = accept && (job.va || last_unit);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      held_high  <= '0;
    end else if (accept) begin
      held_valid <= u_high && !last_unit;
      held_high  <= code_unit;
    end
  end

endmodule
`default_nettype wire

// File: rtl/u16u8_queue.sv
// short job queue between the front end and the byte emitter
`timescale 1ns / 1ps
`default_nettype none
module u16u8_queue #(
  parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire u16u8_pkg::job_t wdata,
  input  wire logic            pop,
  output u16u8_pkg::job_t      rdata,
  output logic                 full,
  output logic                 empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  u16u8_pkg::job_t slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full  = count == FULL_COUNT;
  assign empty = count == '0;
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/u16u8_back.sv
// back end: capacity check and byte-by-byte utf-8 emission into the output register
`timescale 1ns / 1ps
`default_nettype none
module u16u8_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire u16u8_pkg::cfg_t   cfg,
  input  wire u16u8_pkg::job_t   job,
  input  wire logic              empty,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             out_byte,
  output logic                   has_byte,
  output logic                   run_last,
  output logic                   string_done,
  output logic [15:0]            byte_count
);

  logic [15:0] bytes_written;
  logic        capacity_hit;
  logic        busy;
  logic [2:0]  k;
  logic [20:0] p_cpa;
  logic [20:0] p_cpb;
  logic [2:0]  p_na;
  logic [2:0]  p_nb;
  logic [2:0]  p_cnt;
  logic        p_status;
  logic        p_last;
  logic [15:0] p_base;

  logic        fit_a;
  logic        fit_b;
  logic [2:0]  na;
  logic [2:0]  nb;
  logic        hit_a;
  logic        hit_b;
  logic [15:0] bw_a;
  logic [2:0]  n_bytes;
  logic        adv;
  logic        finishing;
  logic        in_a;
  logic [7:0]  cur_byte;

  always_comb begin
    fit_a   = job.va && !capacity_hit &&
              (({1'b0, bytes_written} + 17'(job.sza)) <= {1'b0, cfg.out_capacity});
    na      = fit_a ? job.sza : 3'd0;
    hit_a   = capacity_hit || (job.va && !fit_a);
    bw_a    = bytes_written + 16'(na);
    fit_b   = job.vb && !hit_a &&
              (({1'b0, bw_a} + 17'(job.szb)) <= {1'b0, cfg.out_capacity});
    nb      = fit_b ? job.szb : 3'd0;
    hit_b   = hit_a || (job.vb && !fit_b);
    n_bytes = na + nb;
  end

  assign adv       = busy && (!out_valid || !out_stall);
  assign finishing = adv && (k == p_cnt - 3'd1);
  assign pop       = !empty && (!busy || finishing);

  always_comb begin
    in_a = k < p_na;
    if (in_a) begin
      cur_byte = u16u8_pkg::utf8_byte(p_cpa, p_na, k);
    end else begin
      cur_byte = u16u8_pkg::utf8_byte(p_cpb, p_nb, k - p_na);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_written <= '0;
      capacity_hit  <= 1'b0;
      busy          <= 1'b0;
      k             <= '0;
    end else begin
      if (adv) begin
        k <= k + 3'd1;
      end
      if (finishing) begin
        busy <= 1'b0;
      end
      if (pop) begin
        busy <= (n_bytes != 3'd0) || job.last;
        k    <= '0;
        if (job.last) begin
          bytes_written <= '0;
          capacity_hit  <= 1'b0;
        end else begin
          bytes_written <= bw_a + 16'(nb);
          capacity_hit  <= hit_b;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      p_cpa    <= job.cpa;
      p_cpb    <= job.cpb;
      p_na     <= na;
      p_nb     <= nb;
      p_cnt    <= (n_bytes == 3'd0) ? 3'd1 : n_bytes;
      p_status <= n_bytes == 3'd0;
      p_last   <= job.last;
      p_base   <= bytes_written;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte    <= p_status ? u16u8_pkg::NULL_BYTE : cur_byte;
      has_byte    <= !p_status;
      run_last    <= k == p_cnt - 3'd1;
      string_done <= p_last && (k == p_cnt - 3'd1);
      byte_count  <= p_status ? p_base : p_base + 16'(k) + 16'd1;
    end
  end

endmodule
`default_nettype wire
